FILE: rtl/pfad_pkg.sv
// ============================================================================
// pfad_pkg
// Shared widths, constants and types of the PWM feedback angle decoder.
// ============================================================================
package pfad_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int DUTY_W   = 16;
    localparam int TURN_W   = 16;
    localparam int OFFS_W   = 21;
    localparam int ANGLE_W  = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = OFFS_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DUTY   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DUTY   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_RECAL = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INVERT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET     = 3'd4;

    // Reset values of the working bounds
    localparam logic [DUTY_W-1:0] MIN_DUTY_RST = 16'd1900;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 16'd63635;
    localparam logic [DUTY_W-1:0] DUTY_FULL    = '1;

    // Shared divider: remainder/divisor width covers high + low time,
    // quotient register covers the angle quotient magnitude
    localparam int P_W   = TIME_W + 1;
    localparam int Q_W   = 29;
    localparam int CNT_W = 5;

    localparam logic [CNT_W-1:0] DUTY_STEPS = CNT_W'(DUTY_W);
    localparam logic [CNT_W-1:0] ANG_STEPS  = CNT_W'(Q_W);

    // Angle scaling: 1/16 degree per unit, 5760 units per turn
    localparam int MUL_W = 31;
    localparam logic signed [13:0] UNITS_PER_TURN = 14'sd5760;

    // Command to the shared divider
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } t_div_cmd;

endpackage

FILE: rtl/pfad_divider.sv
// ============================================================================
// pfad_divider
// Shared restoring divider, one quotient bit per cycle. The remainder can be
// preloaded, so the same unit forms both the duty fraction and the angle.
// ============================================================================
module pfad_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfad_pkg::t_div_cmd          i_cmd,
    input  logic [pfad_pkg::P_W-1:0]    i_rem_init,
    input  logic [pfad_pkg::Q_W-1:0]    i_dividend,
    input  logic [pfad_pkg::P_W-1:0]    i_divisor,
    output logic                        o_busy,
    output logic [pfad_pkg::Q_W-1:0]    o_quot
);

    logic [pfad_pkg::CNT_W-1:0] r_cnt;
    logic [pfad_pkg::P_W-1:0]   r_rem;
    logic [pfad_pkg::P_W-1:0]   r_div;
    logic [pfad_pkg::Q_W-1:0]   r_quot;

    logic [pfad_pkg::P_W:0]     w_shift;
    logic [pfad_pkg::P_W+1:0]   w_diff;
    logic                       w_ge;

    // One shift-and-subtract step
    always_comb begin
        w_shift = {r_rem, r_quot[pfad_pkg::Q_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_div};
        w_ge    = ~w_diff[pfad_pkg::P_W+1];
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_cnt <= i_cmd.steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= i_rem_init;
            r_div  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? w_diff[pfad_pkg::P_W-1:0] : w_shift[pfad_pkg::P_W-1:0];
            r_quot <= {r_quot[pfad_pkg::Q_W-2:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

FILE: rtl/pwm_feedback_angle_decoder.sv
// ============================================================================
// pwm_feedback_angle_decoder
// Decodes timestamped edges of a servo feedback PWM into duty fraction,
// whole-turn count and signed angle in 1/16 degree.
// ============================================================================
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------
//  s_axis   | in  | tvalid / tready      | tuser: edge_rising; tdata: edge_time
//  m_axis   | out | tvalid / tready      | tuser: duty_updated;
//           |     |                      | tdata: duty, turns, angle
//  cfg      | in  | valid / ready        | addr: register index; data: value
//
//  A rising edge runs 16 divider steps for the duty fraction and 29 for the
//  angle term, on the one shared divider. A falling edge skips the duty
//  division. Zero period or zero low time skips the duty division; equal
//  working bounds skip the angle division.
//  Edges are taken only in the idle state; the result sits in an output
//  register, so the next edge may be taken while it waits for a transfer.
//  Reset is synchronous, active low; the configuration port is always ready.
// ============================================================================
module pwm_feedback_angle_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input edges
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [pfad_pkg::TIME_W-1:0]         i_s_axis_tdata,   // [31:0] edge_time
    input  logic                                i_s_axis_tuser,   // [0] edge_rising
    // results
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] duty_fraction, [31:16] turn_count, [63:32] angle
    output logic [63:0]                         o_m_axis_tdata,
    output logic                                o_m_axis_tuser,   // [0] duty_updated
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pfad_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pfad_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SPLIT    = 10'b00_0000_0010,
        S_DUTY     = 10'b00_0000_0100,
        S_CLAMP    = 10'b00_0000_1000,
        S_TURN     = 10'b00_0001_0000,
        S_ANG_MUL  = 10'b00_0010_0000,
        S_ANG_DIV  = 10'b00_0100_0000,
        S_ANG_WAIT = 10'b00_1000_0000,
        S_SIGN     = 10'b01_0000_0000,
        S_FINAL    = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic                               r_auto;
    logic                               r_invert;
    logic signed [pfad_pkg::OFFS_W-1:0] r_offset;

    // decoder state
    logic [pfad_pkg::TIME_W-1:0]        r_last_rise, r_last_fall;
    logic [pfad_pkg::DUTY_W-1:0]        r_prev_duty;
    logic [pfad_pkg::TURN_W-1:0]        r_turns;
    logic [pfad_pkg::DUTY_W-1:0]        r_work_min, r_work_max;

    // per-item working registers
    logic                               r_rising;
    logic [pfad_pkg::TIME_W-1:0]        r_hi, r_lo;
    logic [pfad_pkg::DUTY_W-1:0]        r_duty;
    logic signed [pfad_pkg::MUL_W-1:0]  r_num, r_tbase;
    logic signed [pfad_pkg::DUTY_W:0]   r_span;
    logic                               r_q_neg;
    logic signed [pfad_pkg::ANGLE_W-1:0] r_acc;
    logic signed [pfad_pkg::ANGLE_W:0]  r_acc_s;

    // output register
    logic                               r_m_tvalid;
    logic [63:0]                        r_m_tdata;
    logic                               r_m_tuser;

    // divider hookup
    pfad_pkg::t_div_cmd                 w_div_cmd;
    logic [pfad_pkg::P_W-1:0]           w_div_rem, w_div_dvs;
    logic [pfad_pkg::Q_W-1:0]           w_div_dvd, w_div_quot;
    logic                               w_div_busy;

    logic                               w_in_xfer, w_cfg_xfer, w_out_load;
    logic [pfad_pkg::P_W-1:0]           w_period;
    logic signed [19:0]                 w_span20, w_3span, w_d4, w_p4;
    logic signed [pfad_pkg::DUTY_W:0]   w_dnum;
    logic [pfad_pkg::MUL_W-1:0]         w_num_abs;
    logic [pfad_pkg::DUTY_W:0]          w_span_abs;
    logic signed [pfad_pkg::MUL_W-1:0]  w_qs;
    logic signed [pfad_pkg::ANGLE_W+1:0] w_fin;
    logic [pfad_pkg::ANGLE_W-1:0]       w_angle;

    assign w_in_xfer  = i_s_axis_tvalid & o_s_axis_tready;
    assign w_cfg_xfer = i_cfg_valid & o_cfg_ready;
    assign w_out_load = (r_state == S_FINAL) & (~r_m_tvalid | i_m_axis_tready);

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    always_comb begin
        w_period   = {1'b0, r_hi} + {1'b0, r_lo};
        // quarter tests on the (possibly updated) working span
        w_span20   = 20'($signed({1'b0, r_work_max}) - $signed({1'b0, r_work_min}));
        w_3span    = w_span20 + (w_span20 <<< 1);
        w_d4       = $signed({2'b00, r_duty, 2'b00});
        w_p4       = $signed({2'b00, r_prev_duty, 2'b00});
        w_dnum     = $signed({1'b0, r_prev_duty}) - $signed({1'b0, r_work_min});
        // magnitudes for the angle division
        w_num_abs  = r_num[pfad_pkg::MUL_W-1] ? pfad_pkg::MUL_W'(-r_num)
                                               : pfad_pkg::MUL_W'(r_num);
        w_span_abs = r_span[pfad_pkg::DUTY_W] ? (pfad_pkg::DUTY_W+1)'(-r_span)
                                              : (pfad_pkg::DUTY_W+1)'(r_span);
        // signed quotient
        w_qs       = r_q_neg ? -$signed({2'b00, w_div_quot})
                             :  $signed({2'b00, w_div_quot});
        // offset and saturation
        w_fin      = (pfad_pkg::ANGLE_W+2)'(r_acc_s) - (pfad_pkg::ANGLE_W+2)'(r_offset);
        if (w_fin[pfad_pkg::ANGLE_W+1:pfad_pkg::ANGLE_W-1] == 3'b000 ||
            w_fin[pfad_pkg::ANGLE_W+1:pfad_pkg::ANGLE_W-1] == 3'b111) begin
            w_angle = w_fin[pfad_pkg::ANGLE_W-1:0];
        end else if (w_fin[pfad_pkg::ANGLE_W+1]) begin
            w_angle = {1'b1, {(pfad_pkg::ANGLE_W-1){1'b0}}};
        end else begin
            w_angle = {1'b0, {(pfad_pkg::ANGLE_W-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------
    // Divider operand select
    // ------------------------------------------------------------------
    always_comb begin
        w_div_cmd.start = 1'b0;
        w_div_cmd.steps = pfad_pkg::DUTY_STEPS;
        w_div_rem       = {1'b0, r_hi};
        w_div_dvd       = '0;
        w_div_dvs       = w_period;
        if (r_state == S_SPLIT) begin
            w_div_cmd.start = (w_period != '0) && (r_lo != '0);
        end else if (r_state == S_ANG_DIV) begin
            w_div_cmd.start = (r_span != '0);
            w_div_cmd.steps = pfad_pkg::ANG_STEPS;
            w_div_rem       = '0;
            w_div_dvd       = w_num_abs[pfad_pkg::Q_W-1:0];
            w_div_dvs       = {{(pfad_pkg::P_W-pfad_pkg::DUTY_W-1){1'b0}}, w_span_abs};
        end
    end

    pfad_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_div_cmd),
        .i_rem_init (w_div_rem),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_in_xfer) n_state = i_s_axis_tuser ? S_SPLIT : S_ANG_MUL;
            S_SPLIT:    n_state = w_div_cmd.start ? S_DUTY : S_CLAMP;
            S_DUTY:     if (!w_div_busy) n_state = S_CLAMP;
            S_CLAMP:    n_state = S_TURN;
            S_TURN:     n_state = S_ANG_MUL;
            S_ANG_MUL:  n_state = S_ANG_DIV;
            S_ANG_DIV:  n_state = w_div_cmd.start ? S_ANG_WAIT : S_SIGN;
            S_ANG_WAIT: if (!w_div_busy) n_state = S_SIGN;
            S_SIGN:     n_state = S_FINAL;
            S_FINAL:    if (w_out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Edge timing, duty, bounds, turn count and configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rise <= '0;
            r_last_fall <= '0;
            r_prev_duty <= '0;
            r_turns     <= '0;
            r_work_min  <= pfad_pkg::MIN_DUTY_RST;
            r_work_max  <= pfad_pkg::MAX_DUTY_RST;
            r_auto      <= 1'b0;
            r_invert    <= 1'b0;
            r_offset    <= '0;
        end else begin
            // edge capture
            if (w_in_xfer) begin
                if (i_s_axis_tuser) begin
                    r_last_rise <= i_s_axis_tdata;
                end else begin
                    r_last_fall <= i_s_axis_tdata;
                end
            end
            // clamp, or widen the bounds
            if (r_state == S_CLAMP) begin
                if (r_duty > r_work_max) begin
                    if (r_auto) r_work_max <= r_duty;
                end else if (r_duty < r_work_min) begin
                    if (r_auto) r_work_min <= r_duty;
                end
            end
            // quarter crossings
            if (r_state == S_TURN) begin
                r_prev_duty <= r_duty;
                if (w_d4 <= w_span20 && w_p4 >= w_3span) begin
                    r_turns <= r_turns + 1'b1;
                end else if (w_d4 >= w_3span && w_p4 <= w_span20) begin
                    r_turns <= r_turns - 1'b1;
                end
            end
            // register writes
            if (w_cfg_xfer) begin
                case (i_cfg_addr)
                    pfad_pkg::CFG_MIN_DUTY:
                        r_work_min <= i_cfg_data[pfad_pkg::DUTY_W-1:0];
                    pfad_pkg::CFG_MAX_DUTY:
                        r_work_max <= i_cfg_data[pfad_pkg::DUTY_W-1:0];
                    pfad_pkg::CFG_AUTO_RECAL: r_auto   <= i_cfg_data[0];
                    pfad_pkg::CFG_INVERT:     r_invert <= i_cfg_data[0];
                    pfad_pkg::CFG_OFFSET:     r_offset <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-item working registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_rising <= i_s_axis_tuser;
            r_hi     <= r_last_fall - r_last_rise;
            r_lo     <= i_s_axis_tdata - r_last_fall;
        end
        case (r_state)
            S_SPLIT: begin
                if (w_period == '0)   r_duty <= '0;
                else if (r_lo == '0)  r_duty <= pfad_pkg::DUTY_FULL;
            end
            S_DUTY:
                if (!w_div_busy) r_duty <= w_div_quot[pfad_pkg::DUTY_W-1:0];
            S_CLAMP: begin
                if (r_duty > r_work_max) begin
                    if (!r_auto) r_duty <= r_work_max;
                end else if (r_duty < r_work_min) begin
                    if (!r_auto) r_duty <= r_work_min;
                end
            end
            S_ANG_MUL: begin
                // operands widened first so the product keeps its full width
                r_num   <= pfad_pkg::MUL_W'(w_dnum)
                           * pfad_pkg::MUL_W'(pfad_pkg::UNITS_PER_TURN);
                r_tbase <= pfad_pkg::MUL_W'($signed(r_turns))
                           * pfad_pkg::MUL_W'(pfad_pkg::UNITS_PER_TURN);
                r_span  <= (pfad_pkg::DUTY_W+1)'(w_span20);
            end
            S_ANG_DIV: begin
                r_q_neg <= r_num[pfad_pkg::MUL_W-1] ^ r_span[pfad_pkg::DUTY_W];
                if (r_span == '0) r_acc <= pfad_pkg::ANGLE_W'(r_tbase);
            end
            S_ANG_WAIT:
                if (!w_div_busy) begin
                    r_acc <= pfad_pkg::ANGLE_W'(r_tbase) + pfad_pkg::ANGLE_W'(w_qs);
                end
            S_SIGN:
                r_acc_s <= r_invert ? -(pfad_pkg::ANGLE_W+1)'(r_acc)
                                    :  (pfad_pkg::ANGLE_W+1)'(r_acc);
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_tdata <= {w_angle, r_turns, r_prev_duty};
            r_m_tuser <= r_rising;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_div_busy)
        else $error("edge taken while divider busy");

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == S_DUTY || r_state == S_ANG_WAIT))
        else $error("divider running outside a wait state");

    a_duty_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TURN && r_work_min <= r_work_max)
            |-> (r_duty >= r_work_min && r_duty <= r_work_max))
        else $error("duty outside working bounds after clamp");

    a_turn_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TURN) |=> (r_turns == $past(r_turns) ||
                                 r_turns == $past(r_turns) + 16'd1 ||
                                 r_turns == $past(r_turns) - 16'd1))
        else $error("turn count moved by more than one");

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_FINAL))
        else $error("result raised outside final state");

endmodule
